@@ hdl/uvst_pkg.sv @@
package uvst_pkg;

    localparam int SEG_MAX    = 256;
    localparam int ANGLE_BITS = 12;
    localparam int QUARTER    = 1 << (ANGLE_BITS - 2);

    localparam int ANG_W  = ANGLE_BITS;
    localparam int SIN_AW = ANGLE_BITS - 1;
    localparam int SIN_W  = 15;
    localparam int SEG_W  = 9;
    localparam int LAT_W  = 8;
    localparam int QUO_W  = 17;
    localparam int REM_W  = 9;
    localparam int CFG_IDX_W = 3;

    // dividends for the per-start step setup
    localparam logic [QUO_W-1:0] DIVD_TEX = QUO_W'(1 << 16);
    localparam logic [QUO_W-1:0] DIVD_LON = QUO_W'(1 << ANGLE_BITS);
    localparam logic [QUO_W-1:0] DIVD_LAT = QUO_W'(1 << (ANGLE_BITS - 1));

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RADIUS   = 3'd0,
        CFG_SEGMENTS = 3'd1,
        CFG_CENTER_X = 3'd2,
        CFG_CENTER_Y = 3'd3,
        CFG_CENTER_Z = 3'd4
    } cfg_idx_t;

    typedef logic [SIN_W-1:0] qsin_rom_t [0:QUARTER];

    // Quarter-wave sine, Q1.14, from a fixed-point Taylor series (Q30).
    // Evaluated at elaboration only.
    function automatic qsin_rom_t qsin_gen();
        qsin_rom_t tab;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        longint unsigned s;
        for (int r = 0; r <= QUARTER; r++) begin
            x  = (longint'(r) * 64'd1686629713 + longint'(QUARTER >> 1)) >> (ANGLE_BITS - 2);
            x2 = (x * x) >> 30;
            t  = 64'd1 << 30;
            t  = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd110;
            t  = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd72;
            t  = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd42;
            t  = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd20;
            t  = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd6;
            s = (x * t) >> 30;
            s = (s + (64'd1 << 15)) >> 16;
            if (s > 64'd16384) begin
                s = 64'd16384;
            end
            tab[r] = s[SIN_W-1:0];
        end
        return tab;
    endfunction

endpackage

@@ hdl/uvst_sin.sv @@
module uvst_sin
    import uvst_pkg::*;
(
    input  logic                    aclk,
    input  logic [ANG_W-1:0]        angle,
    output logic signed [SIN_W:0]   value
);

    localparam qsin_rom_t ROM = qsin_gen();

    logic [SIN_W-1:0]  rom_q_reg;
    logic              neg_reg;
    logic [1:0]        quad;
    logic [ANG_W-3:0]  frac;
    logic [SIN_AW-1:0] addr;

    always_comb begin
        quad = angle[ANG_W-1:ANG_W-2];
        frac = angle[ANG_W-3:0];
        addr = quad[0] ? (SIN_AW'(QUARTER) - {1'b0, frac}) : {1'b0, frac};
    end

    always_ff @(posedge aclk) begin
        rom_q_reg <= ROM[addr];
        neg_reg   <= quad[1];
    end

    assign value = neg_reg ? -$signed({1'b0, rom_q_reg}) : $signed({1'b0, rom_q_reg});

endmodule

@@ hdl/uvst_div.sv @@
module uvst_div
    import uvst_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [QUO_W-1:0] dividend,
    input  logic [REM_W-1:0] divisor,
    output logic             done,
    output logic [QUO_W-1:0] quotient,
    output logic [REM_W-1:0] remainder
);

    logic [4:0]       cnt_reg;
    logic             done_reg;
    logic [QUO_W-1:0] quo_reg;
    logic [REM_W-1:0] rem_reg;
    logic [REM_W-1:0] dsr_reg;
    logic [REM_W:0]   trial;
    logic             ge;

    always_comb begin
        trial = {rem_reg, quo_reg[QUO_W-1]};
        ge    = trial >= {1'b0, dsr_reg};
    end

    // restoring division, one quotient bit a cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else if (start) begin
            cnt_reg  <= 5'(QUO_W);
            done_reg <= 1'b0;
            quo_reg  <= dividend;
            rem_reg  <= '0;
            dsr_reg  <= divisor;
        end else if (cnt_reg != '0) begin
            cnt_reg  <= cnt_reg - 5'd1;
            done_reg <= (cnt_reg == 5'd1);
            quo_reg  <= {quo_reg[QUO_W-2:0], ge};
            rem_reg  <= ge ? REM_W'(trial - {1'b0, dsr_reg}) : trial[REM_W-1:0];
        end else begin
            done_reg <= 1'b0;
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

@@ hdl/uv_sphere_tessellator.sv @@
// Channel  Dir  Payload
// s_       in   tdata[7:0]: start_req in bit 0
// m_       out  tdata[183:0]: coords, normals, u/v; tuser: is_triangle; tlast: final_res
// cfg_     in   index[2:0], data[31:0]; always ready
//
// One word at a time. A triangle word goes from accept through S_EXEC and S_OUT to
// the output register; a pole vertex adds three passes through one 32x16 multiplier,
// and a ring vertex first adds four sine ROM reads on one port.
// A start word adds a step setup of four serial divisions.
// Reset is synchronous, active low. A stalled m_ side holds one finished word
// while the next input word is already taken.
module uv_sphere_tessellator
    import uvst_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // [0] start_req
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [31:0] coord_a, [63:32] coord_b, [95:64] coord_c, [111:96] normal_x,
    // [127:112] normal_y, [143:128] normal_z, [160:144] tex_u, [177:161] tex_v
    output logic [183:0]         m_tdata,
    output logic [0:0]           m_tuser,   // [0] is_triangle
    output logic                 m_tlast,   // final_res
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE, S_DIV, S_EXEC, S_RD0, S_RD1, S_RD2, S_RD3, S_RD4,
        S_NRM, S_MUL, S_POS, S_OUT
    } st_t;

    typedef enum logic [2:0] {
        PH_IDLE, PH_TOP, PH_RING, PH_BOT, PH_TCAP, PH_TBODY, PH_BCAP
    } ph_t;

    typedef enum logic [1:0] {
        JOB_TEX_U, JOB_LON, JOB_TEX_V, JOB_LAT
    } job_t;

    typedef struct packed {
        logic [QUO_W-1:0] q;
        logic [REM_W-1:0] r;
    } acc_t;

    localparam logic signed [15:0] N_ONE  = 16'sd16384;
    localparam logic [16:0]        UV_HALF = 17'd32768;
    localparam logic [16:0]        UV_ONE  = 17'd65536;

    // quotient/remainder step: (q,r) + (kq,kr) modulo divisor d
    function automatic acc_t acc_step(input acc_t a, input acc_t k, input logic [REM_W-1:0] d);
        acc_t      n;
        logic [REM_W:0] s;
        s = {1'b0, a.r} + {1'b0, k.r};
        if (s >= {1'b0, d}) begin
            n.r = REM_W'(s - {1'b0, d});
            n.q = a.q + k.q + QUO_W'(1);
        end else begin
            n.r = s[REM_W-1:0];
            n.q = a.q + k.q;
        end
        return n;
    endfunction

    // shift right by 14, rounding half away from zero
    function automatic logic signed [34:0] rnd14(input logic signed [47:0] v);
        logic [47:0] m;
        logic [33:0] q;
        m = v[47] ? 48'(-v) : 48'(v);
        q = 34'((m + 48'd8192) >> 14);
        return v[47] ? -$signed({1'b0, q}) : $signed({1'b0, q});
    endfunction

    function automatic logic [31:0] sat32(input logic signed [35:0] s);
        if (s > 36'sd2147483647) begin
            return 32'h7FFF_FFFF;
        end else if (s < -36'sd2147483648) begin
            return 32'h8000_0000;
        end else begin
            return s[31:0];
        end
    endfunction

    // configuration registers
    logic [30:0]        radius_reg;
    logic [SEG_W-1:0]   segments_reg;
    logic signed [31:0] center_x_reg, center_y_reg, center_z_reg;

    // values latched at start
    logic [30:0]        lrad_reg;
    logic signed [31:0] lcx_reg, lcy_reg, lcz_reg;
    logic [SEG_W-1:0]   lon_reg;
    logic [LAT_W-1:0]   lat_reg;

    st_t               state_reg;
    ph_t               phase_reg;
    job_t              job_reg;
    logic              div_start_reg;
    logic [LAT_W-1:0]  ring_reg;
    logic [SEG_W-1:0]  col_reg;
    logic              half_reg;
    logic [15:0]       vidx_reg;
    logic [1:0]        axis_reg;

    // per-start steps and running angle / texture accumulators
    acc_t ku_reg, kta_reg, kv_reg, kpa_reg;
    acc_t au_reg, ata_reg, av_reg, apa_reg;

    // vertex work registers
    logic [ANG_W-1:0]   pa_reg, ta_reg;
    logic signed [15:0] sp_reg, cp_reg, st_reg;
    logic signed [31:0] pc_reg, ps_reg;
    logic signed [15:0] nx_reg, ny_reg, nz_reg;
    logic [16:0]        u_reg, v_reg;
    logic signed [47:0] mprod_reg;

    // staged result
    logic        res_tri_reg, res_fin_reg;
    logic [31:0] res_a_reg, res_b_reg, res_c_reg;

    // output register
    logic         m_tvalid_reg;
    logic [183:0] m_tdata_reg;
    logic         m_tuser_reg, m_tlast_reg;

    // combinational helpers
    logic [SEG_W-1:0]   seg_sat;
    logic [SEG_W-1:0]   col_inc;
    logic [LAT_W-1:0]   ring_inc;
    logic [SEG_W-1:0]   lat_d;
    logic [SEG_W-1:0]   rs;
    acc_t               au_nx, ata_nx, av_nx, apa_nx;
    logic [LAT_W-1:0]   rsel;
    logic [16:0]        tri_base;
    logic [15:0]        tri_b16;
    logic [15:0]        bl16;
    logic [ANG_W-1:0]   sin_ang;
    logic signed [15:0] sin_val;
    logic [QUO_W-1:0]   div_dvd;
    logic [REM_W-1:0]   div_dsr;
    logic               div_done;
    logic [QUO_W-1:0]   div_quo;
    logic [REM_W-1:0]   div_rem;
    logic signed [15:0] nsel;
    logic signed [31:0] csel;
    logic [31:0]        pos;

    always_comb begin
        if (segments_reg < SEG_W'(4)) begin
            seg_sat = SEG_W'(4);
        end else if (segments_reg > SEG_W'(SEG_MAX)) begin
            seg_sat = SEG_W'(SEG_MAX);
        end else begin
            seg_sat = segments_reg;
        end
        col_inc  = col_reg + SEG_W'(1);
        ring_inc = ring_reg + LAT_W'(1);
        lat_d    = {1'b0, lat_reg};
        rs       = lon_reg + SEG_W'(1);
        au_nx    = acc_step(au_reg, ku_reg, lon_reg);
        ata_nx   = acc_step(ata_reg, kta_reg, lon_reg);
        av_nx    = acc_step(av_reg, kv_reg, lat_d);
        apa_nx   = acc_step(apa_reg, kpa_reg, lat_d);
        // first index of the current quad row (body) or of the last ring (bottom cap)
        rsel     = (phase_reg == PH_BCAP) ? (lat_reg - LAT_W'(2)) : ring_reg;
        tri_base = 17'(rsel) * 17'(rs) + 17'd1 + {8'd0, col_reg};
        tri_b16  = tri_base[15:0];
        bl16     = tri_b16 + {7'd0, rs};
        case (job_reg)
            JOB_TEX_U: begin div_dvd = DIVD_TEX; div_dsr = lon_reg; end
            JOB_LON:   begin div_dvd = DIVD_LON; div_dsr = lon_reg; end
            JOB_TEX_V: begin div_dvd = DIVD_TEX; div_dsr = lat_d;   end
            JOB_LAT:   begin div_dvd = DIVD_LAT; div_dsr = lat_d;   end
            default:   begin div_dvd = DIVD_TEX; div_dsr = lon_reg; end
        endcase
        case (state_reg)
            S_RD0:   sin_ang = pa_reg;
            S_RD1:   sin_ang = pa_reg + ANG_W'(QUARTER);
            S_RD2:   sin_ang = ta_reg;
            S_RD3:   sin_ang = ta_reg + ANG_W'(QUARTER);
            default: sin_ang = pa_reg;
        endcase
        case (axis_reg)
            2'd0:    begin nsel = nx_reg; csel = lcx_reg; end
            2'd1:    begin nsel = ny_reg; csel = lcy_reg; end
            default: begin nsel = nz_reg; csel = lcz_reg; end
        endcase
        pos = sat32(36'({{4{csel[31]}}, csel}) + 36'(rnd14(mprod_reg)));
    end

    uvst_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start_reg),
        .dividend  (div_dvd),
        .divisor   (div_dsr),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    uvst_sin u_sin (
        .aclk  (aclk),
        .angle (sin_ang),
        .value (sin_val)
    );

    // configuration port
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg   <= 31'd65536;
            segments_reg <= SEG_W'(16);
            center_x_reg <= '0;
            center_y_reg <= '0;
            center_z_reg <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_RADIUS:   radius_reg   <= cfg_data[30:0];
                CFG_SEGMENTS: segments_reg <= cfg_data[SEG_W-1:0];
                CFG_CENTER_X: center_x_reg <= cfg_data;
                CFG_CENTER_Y: center_y_reg <= cfg_data;
                CFG_CENTER_Z: center_z_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            phase_reg     <= PH_IDLE;
            job_reg       <= JOB_TEX_U;
            div_start_reg <= 1'b0;
            ring_reg      <= '0;
            col_reg       <= '0;
            half_reg      <= 1'b0;
            vidx_reg      <= '0;
            axis_reg      <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            div_start_reg <= 1'b0;
            // S_OUT reloads the output register itself
            if (m_tvalid_reg && m_tready && (state_reg != S_OUT)) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        if (s_tdata[0]) begin
                            lon_reg   <= seg_sat;
                            lat_reg   <= seg_sat[SEG_W-1:1];
                            lrad_reg  <= radius_reg;
                            lcx_reg   <= center_x_reg;
                            lcy_reg   <= center_y_reg;
                            lcz_reg   <= center_z_reg;
                            phase_reg <= PH_TOP;
                            ring_reg  <= '0;
                            col_reg   <= '0;
                            half_reg  <= 1'b0;
                            vidx_reg  <= '0;
                            au_reg    <= '{q: '0, r: seg_sat >> 1};
                            ata_reg   <= '{q: '0, r: seg_sat >> 1};
                            av_reg    <= '{q: '0, r: seg_sat >> 2};
                            apa_reg   <= '{q: '0, r: seg_sat >> 2};
                            job_reg   <= JOB_TEX_U;
                            div_start_reg <= 1'b1;
                            state_reg <= S_DIV;
                        end else begin
                            state_reg <= S_EXEC;
                        end
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        case (job_reg)
                            JOB_TEX_U: ku_reg  <= '{q: div_quo, r: div_rem};
                            JOB_LON:   kta_reg <= '{q: div_quo, r: div_rem};
                            JOB_TEX_V: kv_reg  <= '{q: div_quo, r: div_rem};
                            default:   kpa_reg <= '{q: div_quo, r: div_rem};
                        endcase
                        if (job_reg == JOB_LAT) begin
                            state_reg <= S_EXEC;
                        end else begin
                            job_reg       <= job_t'(job_reg + 2'd1);
                            div_start_reg <= 1'b1;
                        end
                    end
                end
                S_EXEC: begin
                    axis_reg <= '0;
                    case (phase_reg)
                        PH_TOP: begin
                            nx_reg    <= '0;
                            ny_reg    <= N_ONE;
                            nz_reg    <= '0;
                            u_reg     <= UV_HALF;
                            v_reg     <= '0;
                            vidx_reg  <= vidx_reg + 16'd1;
                            phase_reg <= PH_RING;
                            ring_reg  <= LAT_W'(1);
                            col_reg   <= '0;
                            av_reg    <= av_nx;
                            apa_reg   <= apa_nx;
                            state_reg <= S_MUL;
                        end
                        PH_RING: begin
                            pa_reg   <= apa_reg.q[ANG_W-1:0];
                            ta_reg   <= ata_reg.q[ANG_W-1:0];
                            u_reg    <= au_reg.q;
                            v_reg    <= av_reg.q;
                            vidx_reg <= vidx_reg + 16'd1;
                            if (col_inc > lon_reg) begin
                                // seam column done: next ring
                                col_reg  <= '0;
                                au_reg   <= '{q: '0, r: lon_reg >> 1};
                                ata_reg  <= '{q: '0, r: lon_reg >> 1};
                                ring_reg <= ring_inc;
                                av_reg   <= av_nx;
                                apa_reg  <= apa_nx;
                                if (ring_inc >= lat_reg) begin
                                    phase_reg <= PH_BOT;
                                end
                            end else begin
                                col_reg <= col_inc;
                                au_reg  <= au_nx;
                                ata_reg <= ata_nx;
                            end
                            state_reg <= S_RD0;
                        end
                        PH_BOT: begin
                            nx_reg    <= '0;
                            ny_reg    <= -N_ONE;
                            nz_reg    <= '0;
                            u_reg     <= UV_HALF;
                            v_reg     <= UV_ONE;
                            vidx_reg  <= vidx_reg + 16'd1;
                            phase_reg <= PH_TCAP;
                            col_reg   <= '0;
                            state_reg <= S_MUL;
                        end
                        PH_TCAP: begin
                            res_tri_reg <= 1'b1;
                            res_fin_reg <= 1'b0;
                            res_a_reg   <= '0;
                            res_b_reg   <= 32'(col_reg) + 32'd1;
                            res_c_reg   <= 32'(col_reg) + 32'd2;
                            if (col_inc >= lon_reg) begin
                                col_reg   <= '0;
                                ring_reg  <= '0;
                                half_reg  <= 1'b0;
                                phase_reg <= (lat_reg > LAT_W'(2)) ? PH_TBODY : PH_BCAP;
                            end else begin
                                col_reg <= col_inc;
                            end
                            state_reg <= S_OUT;
                        end
                        PH_TBODY: begin
                            res_tri_reg <= 1'b1;
                            res_fin_reg <= 1'b0;
                            if (!half_reg) begin
                                res_a_reg <= 32'(tri_b16);
                                res_b_reg <= 32'(bl16);
                                res_c_reg <= 32'(tri_b16 + 16'd1);
                                half_reg  <= 1'b1;
                            end else begin
                                res_a_reg <= 32'(tri_b16 + 16'd1);
                                res_b_reg <= 32'(bl16);
                                res_c_reg <= 32'(bl16 + 16'd1);
                                half_reg  <= 1'b0;
                                if (col_inc >= lon_reg) begin
                                    col_reg  <= '0;
                                    ring_reg <= ring_inc;
                                    if (ring_inc >= lat_reg - LAT_W'(2)) begin
                                        phase_reg <= PH_BCAP;
                                    end
                                end else begin
                                    col_reg <= col_inc;
                                end
                            end
                            state_reg <= S_OUT;
                        end
                        PH_BCAP: begin
                            res_tri_reg <= 1'b1;
                            res_fin_reg <= (col_inc >= lon_reg);
                            res_a_reg   <= 32'(tri_b16);
                            res_b_reg   <= 32'(vidx_reg - 16'd1);
                            res_c_reg   <= 32'(tri_b16 + 16'd1);
                            if (col_inc >= lon_reg) begin
                                phase_reg <= PH_IDLE;
                                col_reg   <= '0;
                            end else begin
                                col_reg <= col_inc;
                            end
                            state_reg <= S_OUT;
                        end
                        default: begin
                            // advance with nothing left: no word
                            state_reg <= S_IDLE;
                        end
                    endcase
                end
                S_RD0: state_reg <= S_RD1;
                S_RD1: begin
                    sp_reg    <= sin_val;
                    state_reg <= S_RD2;
                end
                S_RD2: begin
                    cp_reg    <= sin_val;
                    state_reg <= S_RD3;
                end
                S_RD3: begin
                    st_reg    <= sin_val;
                    state_reg <= S_RD4;
                end
                S_RD4: begin
                    pc_reg    <= 32'(sp_reg) * 32'(sin_val);
                    ps_reg    <= 32'(sp_reg) * 32'(st_reg);
                    state_reg <= S_NRM;
                end
                S_NRM: begin
                    nx_reg    <= 16'(rnd14(48'(pc_reg)));
                    ny_reg    <= cp_reg;
                    nz_reg    <= 16'(rnd14(48'(ps_reg)));
                    state_reg <= S_MUL;
                end
                S_MUL: begin
                    mprod_reg <= $signed({17'd0, lrad_reg}) * 48'(nsel);
                    state_reg <= S_POS;
                end
                S_POS: begin
                    case (axis_reg)
                        2'd0:    res_a_reg <= pos;
                        2'd1:    res_b_reg <= pos;
                        default: res_c_reg <= pos;
                    endcase
                    if (axis_reg == 2'd2) begin
                        res_tri_reg <= 1'b0;
                        res_fin_reg <= 1'b0;
                        state_reg   <= S_OUT;
                    end else begin
                        axis_reg  <= axis_reg + 2'd1;
                        state_reg <= S_MUL;
                    end
                end
                S_OUT: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_tuser_reg  <= res_tri_reg;
                        m_tlast_reg  <= res_fin_reg;
                        if (res_tri_reg) begin
                            m_tdata_reg <= {88'd0, res_c_reg, res_b_reg, res_a_reg};
                        end else begin
                            m_tdata_reg <= {6'd0, v_reg, u_reg, nz_reg, ny_reg, nx_reg,
                                            res_c_reg, res_b_reg, res_a_reg};
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;
    assign m_tlast   = m_tlast_reg;

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
    import uvst_pkg::*;

    localparam int QUIET_LIMIT = 5000;   // cycles with no handshake at all
    localparam int DRAIN_WAIT  = 120;    // start setup plus one ring vertex
    localparam int LOG_MAX     = 10;

    typedef enum logic [2:0] {
        GEN_IDLE, GEN_TOP_POLE, GEN_RINGS, GEN_BOT_POLE,
        GEN_TOP_CAP, GEN_BODY, GEN_BOT_CAP
    } gen_phase_t;

    typedef struct {
        bit          is_tri;
        logic [31:0] a, b, c;
        logic [15:0] nx, ny, nz;
        logic [16:0] u, v;
        bit          fin;
    } element_t;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [7:0]   s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [183:0] m_tdata;
    logic [0:0]   m_tuser;
    logic         m_tlast;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [31:0]  cfg_data;

    uv_sphere_tessellator dut (.*);

    // register copies as the block sees them
    logic [30:0]        reg_radius;
    logic [8:0]         reg_segments;
    logic signed [31:0] reg_cx, reg_cy, reg_cz;

    // generator state, latched at each start word
    gen_phase_t         gen_phase;
    int unsigned        ring_no, col_no, vert_no, lon_n, lat_n;
    bit                 second_half;
    longint             sph_radius, sph_cx, sph_cy, sph_cz;

    element_t           pending_elems[$];
    int                 fail_count;
    int                 log_count;
    int                 quiet_cycles;
    int                 send_idle_pct;
    int                 recv_stall_pct;

    // 20 ns clock
    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // ---------------- predictor ----------------

    // quarter-wave sine in Q1.14, fixed-point series in Q30
    function automatic longint quarter_sine(int unsigned r);
        longint unsigned x, x2, t, s;
        longint unsigned dv [5];
        dv = '{110, 72, 42, 20, 6};
        x  = (longint'(r) * 64'd1686629713 + (QUARTER >> 1)) >> (ANGLE_BITS - 2);
        x2 = (x * x) >> 30;
        t  = 64'd1 << 30;
        for (int i = 0; i < 5; i++)
            t = (64'd1 << 30) - ((x2 * t) >> 30) / dv[i];
        s = (x * t) >> 30;
        s = (s + (64'd1 << 15)) >> 16;
        if (s > 16384) s = 16384;
        return longint'(s);
    endfunction

    function automatic longint wave_sine(int unsigned ang);
        int unsigned quad, r;
        longint      val;
        ang  = ang & ((1 << ANGLE_BITS) - 1);
        quad = ang >> (ANGLE_BITS - 2);
        r    = ang & (QUARTER - 1);
        val  = quad[0] ? quarter_sine(QUARTER - r) : quarter_sine(r);
        return quad[1] ? -val : val;
    endfunction

    // shift right, rounding half away from zero
    function automatic longint round_shift(longint val, int sh);
        longint mag;
        mag = (val < 0) ? -val : val;
        mag = (mag + (longint'(1) << (sh - 1))) >>> sh;
        return (val < 0) ? -mag : mag;
    endfunction

    function automatic logic [31:0] clamp32(longint val);
        if (val > 64'sd2147483647) val = 64'sd2147483647;
        if (val < -64'sd2147483648) val = -64'sd2147483648;
        return val[31:0];
    endfunction

    function automatic element_t vertex_elem(longint nx, longint ny, longint nz,
                                             int unsigned u, int unsigned v);
        element_t e;
        e.is_tri = 1'b0;
        e.a   = clamp32(sph_cx + round_shift(sph_radius * nx, 14));
        e.b   = clamp32(sph_cy + round_shift(sph_radius * ny, 14));
        e.c   = clamp32(sph_cz + round_shift(sph_radius * nz, 14));
        e.nx  = nx[15:0];
        e.ny  = ny[15:0];
        e.nz  = nz[15:0];
        e.u   = u[16:0];
        e.v   = v[16:0];
        e.fin = 1'b0;
        vert_no++;
        return e;
    endfunction

    function automatic element_t tri_elem(int unsigned i0, int unsigned i1,
                                          int unsigned i2, bit fin);
        element_t e;
        e.is_tri = 1'b1;
        e.a = i0; e.b = i1; e.c = i2;
        e.nx = '0; e.ny = '0; e.nz = '0; e.u = '0; e.v = '0;
        e.fin = fin;
        return e;
    endfunction

    // next mesh element for one accepted word; 0 when the word yields nothing
    function automatic bit next_element(bit start, output element_t e);
        int unsigned seg, stride, pa, ta, u, v, tl, bl, last;
        longint      sp, cp, st, ct;
        bit          fin;
        if (start) begin
            seg = reg_segments;
            if (seg < 4) seg = 4;
            if (seg > SEG_MAX) seg = SEG_MAX;
            lon_n = seg;
            lat_n = seg / 2;
            sph_radius = longint'(reg_radius);
            sph_cx = reg_cx; sph_cy = reg_cy; sph_cz = reg_cz;
            gen_phase = GEN_TOP_POLE;
            ring_no = 0; col_no = 0; second_half = 0; vert_no = 0;
        end
        stride = lon_n + 1;
        case (gen_phase)
            GEN_TOP_POLE: begin
                e = vertex_elem(0, 16384, 0, 32768, 0);
                gen_phase = GEN_RINGS; ring_no = 1; col_no = 0;
            end
            GEN_RINGS: begin
                pa = ((ring_no << (ANGLE_BITS - 1)) + lat_n / 2) / lat_n;
                ta = ((col_no << ANGLE_BITS) + lon_n / 2) / lon_n;
                sp = wave_sine(pa); cp = wave_sine(pa + QUARTER);
                st = wave_sine(ta); ct = wave_sine(ta + QUARTER);
                u  = ((col_no << 16) + lon_n / 2) / lon_n;
                v  = ((ring_no << 16) + lat_n / 2) / lat_n;
                e  = vertex_elem(round_shift(sp * ct, 14), cp,
                                 round_shift(sp * st, 14), u, v);
                col_no++;
                if (col_no > lon_n) begin
                    col_no = 0;
                    ring_no++;
                    if (ring_no >= lat_n) gen_phase = GEN_BOT_POLE;
                end
            end
            GEN_BOT_POLE: begin
                e = vertex_elem(0, -16384, 0, 32768, 65536);
                gen_phase = GEN_TOP_CAP; col_no = 0;
            end
            GEN_TOP_CAP: begin
                e = tri_elem(0, 1 + col_no, 2 + col_no, 0);
                col_no++;
                if (col_no >= lon_n) begin
                    col_no = 0; ring_no = 0; second_half = 0;
                    gen_phase = (lat_n > 2) ? GEN_BODY : GEN_BOT_CAP;
                end
            end
            GEN_BODY: begin
                tl = 1 + ring_no * stride + col_no;
                bl = tl + stride;
                if (!second_half) begin
                    e = tri_elem(tl, bl, tl + 1, 0);
                    second_half = 1;
                end else begin
                    e = tri_elem(tl + 1, bl, bl + 1, 0);
                    second_half = 0;
                    col_no++;
                    if (col_no >= lon_n) begin
                        col_no = 0;
                        ring_no++;
                        if (ring_no >= lat_n - 2) gen_phase = GEN_BOT_CAP;
                    end
                end
            end
            GEN_BOT_CAP: begin
                last = 1 + (lat_n - 2) * stride + col_no;
                fin  = (col_no + 1 >= lon_n);
                e = tri_elem(last, vert_no - 1, last + 1, fin);
                col_no++;
                if (fin) begin
                    gen_phase = GEN_IDLE; col_no = 0;
                end
            end
            default: return 1'b0;
        endcase
        return 1'b1;
    endfunction

    // ---------------- drivers ----------------

    task automatic send_word(bit start);
        element_t e;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, start};
        do @(posedge aclk); while (!s_tready);
        if (next_element(start, e))
            pending_elems.push_back(e);
    endtask

    // block idle: every expected word seen, then room for work in flight
    task automatic drain_block();
        s_tvalid <= 1'b0;
        while (pending_elems.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_RADIUS:   reg_radius   = val[30:0];
            CFG_SEGMENTS: reg_segments = val[8:0];
            CFG_CENTER_X: reg_cx       = val;
            CFG_CENTER_Y: reg_cy       = val;
            CFG_CENTER_Z: reg_cz       = val;
            default: ;
        endcase
    endtask

    function automatic int sphere_words(int unsigned seg);
        int unsigned l, h;
        l = (seg < 4) ? 4 : (seg > SEG_MAX) ? SEG_MAX : seg;
        h = l / 2;
        return 2 + (h - 1) * (l + 1) + 2 * l + 2 * l * (h - 2);
    endfunction

    // ---------------- tests ----------------

    // advance before any start, smallest sphere from a zero segment count,
    // advance after the last triangle, oversized count restarted mid-sphere
    task automatic test_directed();
        send_word(1'b0);
        send_word(1'b0);
        drain_block();
        write_reg(CFG_SEGMENTS, 32'd0);
        send_word(1'b1);
        repeat (sphere_words(0) - 1) send_word(1'b0);
        send_word(1'b0);
        drain_block();
        write_reg(CFG_SEGMENTS, 32'h1FF);
        send_word(1'b1);
        send_word(1'b0);
        send_word(1'b0);
        send_word(1'b1);
        send_word(1'b0);
        drain_block();
    endtask

    function automatic logic [31:0] pick_center();
        case ($urandom_range(5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'd0;
            default: return $urandom();
        endcase
    endfunction

    // random spheres; some complete, others cut short by a restart
    task automatic test_random_spheres(int words, int idle_pct, int stall_pct);
        int          sent, n, seg;
        logic [31:0] rad;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        sent = 0;
        while (sent < words) begin
            drain_block();
            case ($urandom_range(9))
                0: rad = 32'h7FFF_FFFF;
                1: rad = 32'd0;
                2, 3: rad = $urandom();
                default: rad = $urandom_range(32'h0004_0000);
            endcase
            write_reg(CFG_RADIUS, rad);
            write_reg(CFG_CENTER_X, pick_center());
            write_reg(CFG_CENTER_Y, pick_center());
            write_reg(CFG_CENTER_Z, pick_center());
            case ($urandom_range(19))
                0: seg = $urandom_range(3);
                1: seg = $urandom_range(511);
                2: seg = 256;
                default: seg = $urandom_range(4, 10);
            endcase
            write_reg(CFG_SEGMENTS, seg);
            n = sphere_words(seg);
            if (n > 60 || $urandom_range(6) == 0)
                n = $urandom_range(2, (n > 60) ? 40 : n);
            send_word(1'b1);
            sent++;
            for (int i = 1; i < n; i++) begin
                send_word(1'b0);
                sent++;
            end
            // idle advances after a finished sphere yield nothing
            if (n == sphere_words(seg) && $urandom_range(3) == 0) begin
                send_word(1'b0);
                send_word(1'b0);
            end
        end
    endtask

    // ---------------- result checking ----------------

    task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
        fail_count++;
        if (log_count < LOG_MAX)
            $display("%0t mismatch %s: expected %h got %h", $realtime, what, want, got);
        log_count++;
    endtask

    always @(posedge aclk) begin
        element_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_elems.size() == 0) begin
                fail_count++;
                if (log_count < LOG_MAX)
                    $display("%0t unexpected word %h", $realtime, m_tdata);
                log_count++;
            end else begin
                e = pending_elems.pop_front();
                if (m_tuser[0] !== e.is_tri)
                    report_mismatch("is_triangle", e.is_tri, m_tuser[0]);
                if (m_tdata[31:0] !== e.a) report_mismatch("coord_a", e.a, m_tdata[31:0]);
                if (m_tdata[63:32] !== e.b) report_mismatch("coord_b", e.b, m_tdata[63:32]);
                if (m_tdata[95:64] !== e.c) report_mismatch("coord_c", e.c, m_tdata[95:64]);
                if (m_tdata[111:96] !== e.nx)
                    report_mismatch("normal_x", e.nx, m_tdata[111:96]);
                if (m_tdata[127:112] !== e.ny)
                    report_mismatch("normal_y", e.ny, m_tdata[127:112]);
                if (m_tdata[143:128] !== e.nz)
                    report_mismatch("normal_z", e.nz, m_tdata[143:128]);
                if (m_tdata[160:144] !== e.u) report_mismatch("tex_u", e.u, m_tdata[160:144]);
                if (m_tdata[177:161] !== e.v) report_mismatch("tex_v", e.v, m_tdata[177:161]);
                if (m_tlast !== e.fin) report_mismatch("final_res", e.fin, m_tlast);
            end
        end
    end

    // receiver back-pressure
    always @(posedge aclk)
        m_tready <= ($urandom_range(99) >= recv_stall_pct);

    // watchdog on handshake activity
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > QUIET_LIMIT) begin
            $display("FAIL uv_sphere_tessellator");
            $finish;
        end
    end

    // ---------------- sequence ----------------

    initial begin
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        m_tready  <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_RADIUS;
        cfg_data  <= '0;
        fail_count     = 0;
        log_count      = 0;
        send_idle_pct  = 20;
        recv_stall_pct = 51;
        reg_radius = 31'h0001_0000; reg_segments = 9'd16;
        reg_cx = 0; reg_cy = 0; reg_cz = 0;
        gen_phase = GEN_IDLE;
        ring_no = 0; col_no = 0; vert_no = 0; lon_n = 0; lat_n = 0;
        second_half = 0;
        sph_radius = 0; sph_cx = 0; sph_cy = 0; sph_cz = 0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_random_spheres(285, 20, 51);
        test_random_spheres(285, 51, 20);
        test_random_spheres(285, 0, 0);

        drain_block();
        if (fail_count == 0)
            $display("PASS uv_sphere_tessellator");
        else
            $display("FAIL uv_sphere_tessellator");
        $finish;
    end

endmodule
